// ===== sv/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types, constants and helpers for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  // Operand format: signed fixed point, WIDTH bits with FRAC_BITS fraction bits.
  localparam int WIDTH     = 16;
  localparam int FRAC_BITS = 8;

  // Derived widths.
  localparam int PW = 2 * WIDTH;      // product width
  localparam int SW = 2 * WIDTH + 2;  // signed sum of two products
  localparam int CW = 3 * WIDTH;      // remainder and shifted divisor width

  // Operation codes.
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_e;

  // Status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Item state carried through the division stages.
  typedef struct packed {
    func_e             func;
    logic              div0;
    logic              nr;
    logic              ni;
    logic              ovr;
    logic              ovi;
    logic [CW-1:0]     rr;
    logic [CW-1:0]     ri;
    logic [WIDTH-1:0]  qr;
    logic [WIDTH-1:0]  qi;
    logic [PW-1:0]     den;
  } cau_div_t;

  // Result of a saturating conversion.
  typedef struct packed {
    logic [WIDTH-1:0] val;
    logic             sat;
  } cau_clamp_t;

  // Converts a sign and magnitude to a saturated two's complement value.
  function automatic cau_clamp_t cau_clamp(input logic neg, input logic [CW-1:0] mag);
    cau_clamp_t       res;
    logic [CW-1:0]    pos_max;
    logic [CW-1:0]    neg_max;
    logic [CW-1:0]    negated;
    pos_max = (CW'(1) << (WIDTH - 1)) - CW'(1);
    neg_max = CW'(1) << (WIDTH - 1);
    negated = CW'(0) - mag;
    res.sat = 1'b0;
    if (!neg) begin
      if (mag > pos_max) begin
        res.val = pos_max[WIDTH-1:0];
        res.sat = 1'b1;
      end else begin
        res.val = mag[WIDTH-1:0];
      end
    end else begin
      if (mag > neg_max) begin
        res.val = neg_max[WIDTH-1:0];
        res.sat = 1'b1;
      end else begin
        res.val = negated[WIDTH-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on signed Q8.8 parts.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle while the output is not stalled,
// and returns one result per item, in order. The divider resolves one quotient
// bit per pipeline stage. Products and quotients of Q8.8 parts are truncated
// toward zero; a part out of range saturates and reports status 1, and a zero
// divisor gives zero parts with status 2. A stall on a valid output holds the
// whole pipeline, and the input stall follows it in the same cycle.
`default_nettype none

module complex_arith_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 stall_o,
  input  wire logic [1:0]                      func_i,
  input  wire logic signed [cau_pkg::WIDTH-1:0] a_re_i,
  input  wire logic signed [cau_pkg::WIDTH-1:0] a_im_i,
  input  wire logic signed [cau_pkg::WIDTH-1:0] b_re_i,
  input  wire logic signed [cau_pkg::WIDTH-1:0] b_im_i,
  output logic                                 valid_o,
  input  wire logic                            stall_i,
  output logic signed [cau_pkg::WIDTH-1:0]     c_re_o,
  output logic signed [cau_pkg::WIDTH-1:0]     c_im_o,
  output logic [1:0]                           status_o
);

  localparam int W  = cau_pkg::WIDTH;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int PW = cau_pkg::PW;
  localparam int SW = cau_pkg::SW;
  localparam int CW = cau_pkg::CW;

  // The pipeline moves as a whole unless the output holds a stalled result.
  logic en;
  logic out_v_q;
  assign en      = !(out_v_q && stall_i);
  assign stall_o = !en;

  // Stage 1: input registers.
  logic                 s1_v_q;
  cau_pkg::func_e       s1_func_q;
  logic signed [W-1:0]  s1_a_q, s1_b_q, s1_c_q, s1_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_func_q <= cau_pkg::func_e'(func_i);
      s1_a_q    <= a_re_i;
      s1_b_q    <= a_im_i;
      s1_c_q    <= b_re_i;
      s1_d_q    <= b_im_i;
    end
  end

  // Stage 2: the six products and the plain sums and differences.
  logic                 s2_v_q;
  cau_pkg::func_e       s2_func_q;
  logic signed [PW-1:0] s2_ac_q, s2_bd_q, s2_ad_q, s2_bc_q, s2_cc_q, s2_dd_q;
  logic signed [W:0]    s2_lin_re_q, s2_lin_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_func_q <= s1_func_q;
      s2_ac_q   <= s1_a_q * s1_c_q;
      s2_bd_q   <= s1_b_q * s1_d_q;
      s2_ad_q   <= s1_a_q * s1_d_q;
      s2_bc_q   <= s1_b_q * s1_c_q;
      s2_cc_q   <= s1_c_q * s1_c_q;
      s2_dd_q   <= s1_d_q * s1_d_q;
      if (s1_func_q == cau_pkg::FUNC_SUB) begin
        s2_lin_re_q <= (W+1)'(s1_a_q) - (W+1)'(s1_c_q);
        s2_lin_im_q <= (W+1)'(s1_b_q) - (W+1)'(s1_d_q);
      end else begin
        s2_lin_re_q <= (W+1)'(s1_a_q) + (W+1)'(s1_c_q);
        s2_lin_im_q <= (W+1)'(s1_b_q) + (W+1)'(s1_d_q);
      end
    end
  end

  // Stage 3: combine the products or pick the sums, split into sign and magnitude.
  logic signed [SW-1:0] s3_sr, s3_si;
  logic [SW-1:0]        s3_mr, s3_mi;
  logic                 s3_v_q;
  cau_pkg::func_e       s3_func_q;
  logic                 s3_nr_q, s3_ni_q;
  logic [SW-1:0]        s3_mr_q, s3_mi_q;
  logic [PW-1:0]        s3_den_q;

  always_comb begin
    case (s2_func_q)
      cau_pkg::FUNC_ADD, cau_pkg::FUNC_SUB: begin
        s3_sr = SW'(s2_lin_re_q);
        s3_si = SW'(s2_lin_im_q);
      end
      cau_pkg::FUNC_MUL: begin
        s3_sr = SW'(s2_ac_q) - SW'(s2_bd_q);
        s3_si = SW'(s2_ad_q) + SW'(s2_bc_q);
      end
      default: begin
        s3_sr = SW'(s2_ac_q) + SW'(s2_bd_q);
        s3_si = SW'(s2_bc_q) - SW'(s2_ad_q);
      end
    endcase
    s3_mr = s3_sr[SW-1] ? SW'(-s3_sr) : SW'(s3_sr);
    s3_mi = s3_si[SW-1] ? SW'(-s3_si) : SW'(s3_si);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_func_q <= s2_func_q;
      s3_nr_q   <= s3_sr[SW-1];
      s3_ni_q   <= s3_si[SW-1];
      s3_mr_q   <= s3_mr;
      s3_mi_q   <= s3_mi;
      s3_den_q  <= PW'(s2_cc_q) + PW'(s2_dd_q);
    end
  end

  // Stage 4: scale the magnitudes and check the quotient range.
  cau_pkg::cau_div_t s4_d;
  cau_pkg::cau_div_t div_d [0:W];
  cau_pkg::cau_div_t div_q [0:W];
  logic              div_v_q [0:W];
  logic [CW-1:0]     s4_nr, s4_ni, s4_lim;

  always_comb begin
    s4_nr  = CW'(s3_mr_q) << F;
    s4_ni  = CW'(s3_mi_q) << F;
    s4_lim = CW'(s3_den_q) << W;
    s4_d.func = s3_func_q;
    s4_d.nr   = s3_nr_q;
    s4_d.ni   = s3_ni_q;
    s4_d.den  = s3_den_q;
    s4_d.qr   = '0;
    s4_d.qi   = '0;
    s4_d.div0 = (s3_func_q == cau_pkg::FUNC_DIV) && (s3_den_q == '0);
    s4_d.ovr  = 1'b0;
    s4_d.ovi  = 1'b0;
    case (s3_func_q)
      cau_pkg::FUNC_MUL: begin
        s4_d.rr = CW'(s3_mr_q) >> F;
        s4_d.ri = CW'(s3_mi_q) >> F;
      end
      cau_pkg::FUNC_DIV: begin
        s4_d.rr  = s4_nr;
        s4_d.ri  = s4_ni;
        s4_d.ovr = s4_nr >= s4_lim;
        s4_d.ovi = s4_ni >= s4_lim;
      end
      default: begin
        s4_d.rr = CW'(s3_mr_q);
        s4_d.ri = CW'(s3_mi_q);
      end
    endcase
  end

  // Division stages: each resolves one quotient bit, most significant first.
  always_comb begin
    logic [CW-1:0] dsh;
    div_d[0] = s4_d;
    for (int k = 1; k <= W; k++) begin
      div_d[k] = div_q[k-1];
      dsh      = CW'(div_q[k-1].den) << (W - k);
      if (div_q[k-1].func == cau_pkg::FUNC_DIV && !div_q[k-1].div0) begin
        if (!div_q[k-1].ovr && div_q[k-1].rr >= dsh) begin
          div_d[k].rr        = div_q[k-1].rr - dsh;
          div_d[k].qr[W - k] = 1'b1;
        end
        if (!div_q[k-1].ovi && div_q[k-1].ri >= dsh) begin
          div_d[k].ri        = div_q[k-1].ri - dsh;
          div_d[k].qi[W - k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= W; k++) begin
        div_v_q[k] <= 1'b0;
      end
    end else if (en) begin
      div_v_q[0] <= s3_v_q;
      for (int k = 1; k <= W; k++) begin
        div_v_q[k] <= div_v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= W; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // Output stage: pick the magnitude, saturate and form the status.
  cau_pkg::cau_div_t  fin;
  logic [CW-1:0]      fin_mr, fin_mi;
  cau_pkg::cau_clamp_t cl_re, cl_im;

  assign fin = div_q[W];

  always_comb begin
    if (fin.func == cau_pkg::FUNC_DIV) begin
      fin_mr = fin.ovr ? (CW'(1) << W) : CW'(fin.qr);
      fin_mi = fin.ovi ? (CW'(1) << W) : CW'(fin.qi);
    end else begin
      fin_mr = fin.rr;
      fin_mi = fin.ri;
    end
    cl_re = cau_pkg::cau_clamp(fin.nr, fin_mr);
    cl_im = cau_pkg::cau_clamp(fin.ni, fin_mi);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (fin.div0) begin
        c_re_o   <= '0;
        c_im_o   <= '0;
        status_o <= cau_pkg::ST_DIV0;
      end else begin
        c_re_o   <= cl_re.val;
        c_im_o   <= cl_im.val;
        status_o <= (cl_re.sat || cl_im.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
    end
  end

  assign valid_o = out_v_q;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the complex arithmetic unit.
// ----------------------------------------------------------------------------
// Directed operands at the range limits, every operation, saturation, negative
// truncation and zero divisors are sent first, then random items with random
// gaps on the input and random stalls on the output. Each output transfer is
// compared with the oldest prediction kept in a queue.
`timescale 1ns / 1ps

module tb_top;

  localparam int WIDTH     = cau_pkg::WIDTH;
  localparam int FRAC_BITS = cau_pkg::FRAC_BITS;
  localparam int LATENCY   = WIDTH + 5;
  localparam int WD_LIMIT  = 20000;

  typedef struct packed {
    logic signed [WIDTH-1:0] re;
    logic signed [WIDTH-1:0] im;
    cau_pkg::status_e        st;
  } cplx_res_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    valid_i;
  logic                    stall_o;
  logic [1:0]              func_i;
  logic signed [WIDTH-1:0] a_re_i, a_im_i, b_re_i, b_im_i;
  logic                    valid_o;
  logic                    stall_i;
  logic signed [WIDTH-1:0] c_re_o, c_im_o;
  logic [1:0]              status_o;

  cplx_res_t pending_q[$];
  int        err_cnt;
  int        res_cnt;
  int        idle_cyc;
  int        op_cnt[4];

  complex_arith_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(valid_i), .stall_o(stall_o),
    .func_i(func_i), .a_re_i(a_re_i), .a_im_i(a_im_i), .b_re_i(b_re_i),
    .b_im_i(b_im_i), .valid_o(valid_o), .stall_i(stall_i), .c_re_o(c_re_o),
    .c_im_o(c_im_o), .status_o(status_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Saturates a sign and magnitude value; sets sat when it clips.
  function automatic logic [WIDTH-1:0] sat_part(input bit neg, input logic [127:0] mag,
                                                inout bit sat);
    logic [127:0] pmax, nmax;
    pmax = (128'd1 << (WIDTH - 1)) - 1;
    nmax = 128'd1 << (WIDTH - 1);
    if (!neg) begin
      if (mag > pmax) begin
        sat = 1'b1;
        return pmax[WIDTH-1:0];
      end
      return mag[WIDTH-1:0];
    end
    if (mag > nmax) begin
      sat = 1'b1;
      return nmax[WIDTH-1:0];
    end
    return WIDTH'(-mag);
  endfunction

  // Computes the expected result of one operation.
  function automatic cplx_res_t complex_result(input cau_pkg::func_e f,
      input logic signed [WIDTH-1:0] a, b, c, d);
    cplx_res_t     r;
    longint signed xr, xi, den;
    logic [127:0]  mr, mi;
    bit            sat;
    sat = 1'b0;
    den = 0;
    case (f)
      cau_pkg::FUNC_ADD: begin
        xr = a + c;
        xi = b + d;
      end
      cau_pkg::FUNC_SUB: begin
        xr = longint'(a) - c;
        xi = longint'(b) - d;
      end
      cau_pkg::FUNC_MUL: begin
        xr = longint'(a) * c - longint'(b) * d;
        xi = longint'(a) * d + longint'(b) * c;
      end
      default: begin
        xr = longint'(a) * c + longint'(b) * d;
        xi = longint'(b) * c - longint'(a) * d;
        den = longint'(c) * c + longint'(d) * d;
      end
    endcase
    mr = (xr < 0) ? 128'(-xr) : 128'(xr);
    mi = (xi < 0) ? 128'(-xi) : 128'(xi);
    if (f == cau_pkg::FUNC_MUL) begin
      mr = mr >> FRAC_BITS;
      mi = mi >> FRAC_BITS;
    end else if (f == cau_pkg::FUNC_DIV) begin
      if (den == 0) begin
        r.re = '0;
        r.im = '0;
        r.st = cau_pkg::ST_DIV0;
        return r;
      end
      mr = (mr << FRAC_BITS) / 128'(den);
      mi = (mi << FRAC_BITS) / 128'(den);
    end
    r.re = sat_part(xr < 0, mr, sat);
    r.im = sat_part(xi < 0, mi, sat);
    r.st = sat ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    return r;
  endfunction

  // Returns a gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one item and records its prediction at the transfer.
  task automatic send_item(input cau_pkg::func_e f,
                           input logic signed [WIDTH-1:0] a, b, c, d);
    int g;
    g = gap_len();
    if (g > 0) begin
      valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    func_i  <= f;
    a_re_i  <= a;
    a_im_i  <= b;
    b_re_i  <= c;
    b_im_i  <= d;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_q.push_back(complex_result(f, a, b, c, d));
    op_cnt[f]++;
  endtask

  // Lowers valid and waits until all predictions are consumed.
  task automatic wait_drained();
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Random part value with a bias toward the limits and small magnitudes.
  function automatic logic signed [WIDTH-1:0] rand_part();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(WIDTH - 1){1'b1}}};
      1: return {1'b1, {(WIDTH - 1){1'b0}}};
      2: return '0;
      3, 4: return WIDTH'($signed($urandom_range(0, 1023)) - 512);
      default: return WIDTH'($urandom);
    endcase
  endfunction

  // Directed items: extremes, every operation, saturation and zero divisors.
  task automatic test_directed();
    logic signed [WIDTH-1:0] mx, mn;
    mx = {1'b0, {(WIDTH - 1){1'b1}}};
    mn = {1'b1, {(WIDTH - 1){1'b0}}};
    send_item(cau_pkg::FUNC_ADD, 16'sh0100, 16'sh0200, 16'sh0080, -16'sh0040);
    send_item(cau_pkg::FUNC_ADD, mx, mn, mx, mn);
    send_item(cau_pkg::FUNC_ADD, mx, mn, mn, mx);
    send_item(cau_pkg::FUNC_SUB, mx, mn, mn, mx);
    send_item(cau_pkg::FUNC_SUB, mn, mn, mn, mn);
    send_item(cau_pkg::FUNC_SUB, 16'sh0300, -16'sh0100, 16'sh0100, 16'sh0100);
    send_item(cau_pkg::FUNC_MUL, 16'sh0100, 16'sh0000, 16'sh0180, -16'sh0280);
    send_item(cau_pkg::FUNC_MUL, mn, mn, mn, mn);
    send_item(cau_pkg::FUNC_MUL, mx, mx, mx, mn);
    send_item(cau_pkg::FUNC_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000);
    send_item(cau_pkg::FUNC_MUL, -16'sh0003, 16'sh0001, 16'sh0055, 16'sh0007);
    send_item(cau_pkg::FUNC_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000);
    send_item(cau_pkg::FUNC_DIV, mn, mx, 16'sh0000, 16'sh0000);
    send_item(cau_pkg::FUNC_DIV, 16'sh0100, 16'sh0000, 16'sh0200, 16'sh0000);
    send_item(cau_pkg::FUNC_DIV, -16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000);
    send_item(cau_pkg::FUNC_DIV, mx, mx, 16'sh0001, 16'sh0000);
    send_item(cau_pkg::FUNC_DIV, mn, mn, 16'sh0000, 16'sh0001);
    send_item(cau_pkg::FUNC_DIV, mn, mn, mn, mn);
    send_item(cau_pkg::FUNC_DIV, 16'sh0001, 16'sh0001, mx, mx);
    send_item(cau_pkg::FUNC_DIV, 16'sh0123, -16'sh0456, -16'sh0078, 16'sh0009);
  endtask

  // Random items over all operations and full field ranges.
  task automatic test_random(input int n);
    repeat (n) send_item(cau_pkg::func_e'($urandom_range(0, 3)), rand_part(), rand_part(),
                         rand_part(), rand_part());
  endtask

  // Random divides with small divisors and random gaps, held off until drained.
  task automatic test_divide_burst(input int n);
    wait_drained();
    repeat (n) send_item(cau_pkg::FUNC_DIV, WIDTH'($urandom), WIDTH'($urandom),
                         WIDTH'($signed($urandom_range(0, 63)) - 32),
                         WIDTH'($signed($urandom_range(0, 63)) - 32));
  endtask

  // Output stall generator.
  initial begin
    int g;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = gap_len();
      if (g > 0) begin
        stall_i <= 1'b1;
        repeat (g) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    cplx_res_t exp_r;
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= WD_LIMIT) begin
        $display("%0t: watchdog timeout, %0d results outstanding", $time,
                 pending_q.size());
        $display("Simulation FAILED");
        $finish;
      end
      if (valid_o && !stall_i) begin
        res_cnt++;
        if (pending_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected transfer re=%0d im=%0d st=%0d", $time,
                   c_re_o, c_im_o, status_o);
        end else begin
          exp_r = pending_q.pop_front();
          if (c_re_o !== exp_r.re) begin
            err_cnt++;
            $display("%0t: c_re expected %0d actual %0d", $time, exp_r.re, c_re_o);
          end
          if (c_im_o !== exp_r.im) begin
            err_cnt++;
            $display("%0t: c_im expected %0d actual %0d", $time, exp_r.im, c_im_o);
          end
          if (status_o !== exp_r.st) begin
            err_cnt++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status_o);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    err_cnt  = 0;
    res_cnt  = 0;
    idle_cyc = 0;
    rst_ni   = 1'b0;
    valid_i  = 1'b0;
    func_i   = '0;
    a_re_i   = '0;
    a_im_i   = '0;
    b_re_i   = '0;
    b_im_i   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(800);
    test_divide_burst(250);
    test_random(600);
    wait_drained();
    repeat (LATENCY * 2) @(posedge clk_i);
    if (pending_q.size() != 0) err_cnt++;
    $display("Checked %0d results: %0d add, %0d sub, %0d mul, %0d div items.",
             res_cnt, op_cnt[0], op_cnt[1], op_cnt[2], op_cnt[3]);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cau_pkg.sv
sv/complex_arith_unit.sv
test/tb_top.sv
